>>> rtl/msmd_pkg.sv
// Package for the multiscale max deviation unit: widths, codes, states and word types.
`default_nettype none
package msmd_pkg;

  localparam int ELEV_BITS    = 24;
  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 64;
  localparam int CFG_W        = 7;
  localparam int CFG_IDX_W    = 3;
  localparam int DEV_W        = 32;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PADDED_ROWS,
    CFG_PADDED_COLS,
    CFG_PAD_WIDTH,
    CFG_OUT_ROWS,
    CFG_OUT_COLS,
    CFG_RADIUS_MIN,
    CFG_RADIUS_MAX,
    CFG_RADIUS_STEP
  } cfg_index_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_LWR,
    ST_QCHK,
    ST_QCEN,
    ST_RCHK,
    ST_REVAL,
    ST_MNC,
    ST_MNQ,
    ST_MSS,
    ST_MNN,
    ST_DIV,
    ST_SQRT,
    ST_UPD,
    ST_RNXT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                        func;
    logic signed [ELEV_BITS-1:0] elevation;
    logic                        elevation_valid;
    logic [5:0]                  query_row;
    logic [5:0]                  query_col;
  } req_t;

  typedef struct packed {
    logic signed [DEV_W-1:0] deviation;
    logic                    deviation_valid;
  } rsp_t;

endpackage
`default_nettype wire

>>> rtl/msmd_ram.sv
// Simple dual-port RAM: one write port, one registered read port.
`default_nettype none
module msmd_ram #(
  parameter int W  = 8,
  parameter int AW = 4
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [2**AW];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/multiscale_max_deviation_unit.sv
// Top level: summed-area table loader and iterative multiscale z-score query engine.
`default_nettype none
// A load word makes three neighbor reads of the summed-area tables and a write.
// A query word passes through check, centre read and output, plus its radii. The radii
// are walked one at a time through one shared shift-add multiplier, a restoring divider
// and a bit-pair square root. A flat window skips the divide and the root, a saturated
// quotient skips the root, a window with no valid cell skips the arithmetic and a skipped
// radius goes straight on to the next. The divide loop takes the bulk of an evaluated
// radius. After reset a clearing pass over every table address (MAX_ROWS*MAX_COLS, 4096
// at the defaults, rounded up to powers of two per axis) zeroes the summed-area tables; no
// word is taken meanwhile, while configuration writes are. The input is not ready while a
// word is worked on; a finished result waits in the output register while the next word
// enters.
module multiscale_max_deviation_unit #(
  parameter int MAX_ROWS = msmd_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = msmd_pkg::MAX_COLS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              req_valid,
  output logic                                   req_ready,
  input  wire msmd_pkg::req_t                    req,
  output logic                                   rsp_valid,
  input  wire logic                              rsp_ready,
  output msmd_pkg::rsp_t                         rsp,
  input  wire logic                              cfg_we,
  input  wire logic [msmd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [msmd_pkg::CFG_W-1:0]        cfg_data
);

  localparam int E      = msmd_pkg::ELEV_BITS;
  localparam int RAW    = $clog2(MAX_ROWS);
  localparam int CAW    = $clog2(MAX_COLS);
  localparam int AW     = RAW + CAW;
  localparam int RIW    = $clog2(MAX_ROWS + 1);
  localparam int CIW    = $clog2(MAX_COLS + 1);
  localparam int XIW    = (RIW > CIW) ? RIW : CIW;
  localparam int PW     = ((XIW > 7) ? XIW : 7) + 1;
  localparam int CNT_W  = $clog2(MAX_ROWS * MAX_COLS + 1);
  localparam int SUM_W  = E + CNT_W;
  localparam int SQ_W   = 2 * E + CNT_W;
  localparam int NUM_W  = SUM_W + 1;
  localparam int MW     = 2 * NUM_W;
  localparam int DVW    = MW + 32;
  localparam int DCW    = $clog2(DVW + 1);
  localparam int QW     = 62;
  localparam int MAGW   = 31;
  localparam int DEV_W_L = msmd_pkg::DEV_W;
  localparam logic [MAGW-1:0] MAX_MAG = {MAGW{1'b1}};

  msmd_pkg::state_t state, state_next;

  // configuration registers
  logic [6:0] padded_rows, padded_cols, out_rows, out_cols;
  logic [4:0] pad_width, radius_min, radius_max, radius_step;

  logic [RIW-1:0] rows_eff;
  logic [CIW-1:0] cols_eff;
  logic [5:0]     step_eff;

  logic [AW-1:0]  clr_addr;
  logic [RAW-1:0] load_row;
  logic [CAW-1:0] load_col;
  logic           ld_ok;
  logic [E-1:0]   ld_e;
  logic           is_query;

  logic [5:0]     qr, qc;
  logic [PW-1:0]  pr, pc;
  logic [5:0]     rad;
  logic [RIW-1:0] r0, r1;
  logic [CIW-1:0] c0, c1;

  logic [2:0]     rd_k;
  logic           rd_zero, rd_neg;
  logic [CNT_W-1:0] acc_n;
  logic [SUM_W-1:0] acc_s;
  logic [SQ_W-1:0]  acc_q;
  logic [E-1:0]     centre;

  logic [MW-1:0]    mul_a, mul_acc, a_prod, d_val;
  logic [NUM_W-1:0] mul_b, num;
  logic [DVW-1:0]   div_num;
  logic [MW-1:0]    rem;
  logic [QW-1:0]    quo, sq_x, sq_r, sq_bit;
  logic             quo_sat;
  logic [DCW-1:0]   div_cnt;
  logic [MAGW-1:0]  m_val, best_mag;
  logic             have, best_neg;

  // memory ports
  logic             tab_we;
  logic [AW-1:0]    tab_waddr, tab_raddr, cell_raddr, ld_addr;
  logic [CNT_W-1:0] tn_wdata, tn_rdata;
  logic [SUM_W-1:0] ts_wdata, ts_rdata;
  logic [SQ_W-1:0]  tq_wdata, tq_rdata;
  logic             cell_we;
  logic [E:0]       cell_rdata;

  // corner selection
  logic [RIW-1:0] cr;
  logic [CIW-1:0] cc;
  logic           cneg, czero;
  logic [2:0]     ncorners;
  logic           rd_issue, rd_done;

  // misc datapath terms
  logic [E-1:0]     in_mag, cmag;
  logic [2*E-1:0]   in_sq;
  logic [SUM_W-1:0] smag;
  logic [NUM_W-1:0] nmag, prod_s;
  logic [CNT_W-1:0] cap_n;
  logic [SUM_W-1:0] cap_s;
  logic [SQ_W-1:0]  cap_q;
  logic             outside, skip, d_zero, div_ge, sq_ge, out_free;
  logic [MW:0]      div_t;
  logic [QW-1:0]    sq_trial;
  logic [DEV_W_L-1:0] dev_pos;

  // effective raster size and step
  always_comb begin
    if (padded_rows == 7'd0) begin
      rows_eff = RIW'(1);
    end else if (32'(padded_rows) > MAX_ROWS) begin
      rows_eff = RIW'(MAX_ROWS);
    end else begin
      rows_eff = RIW'(padded_rows);
    end
    if (padded_cols == 7'd0) begin
      cols_eff = CIW'(1);
    end else if (32'(padded_cols) > MAX_COLS) begin
      cols_eff = CIW'(MAX_COLS);
    end else begin
      cols_eff = CIW'(padded_cols);
    end
    step_eff = (radius_step == 5'd0) ? 6'd1 : {1'b0, radius_step};
  end

  // pick the table corner for the current read slot
  always_comb begin
    cr   = r1;
    cc   = c1;
    cneg = 1'b0;
    if (is_query) begin
      case (rd_k[1:0])
        2'd0: begin
          cr = r1; cc = c1; cneg = 1'b0;
        end
        2'd1: begin
          cr = r0; cc = c1; cneg = 1'b1;
        end
        2'd2: begin
          cr = r1; cc = c0; cneg = 1'b1;
        end
        default: begin
          cr = r0; cc = c0; cneg = 1'b0;
        end
      endcase
    end else begin
      case (rd_k[1:0])
        2'd0: begin
          cr = RIW'(load_row); cc = CIW'(load_col) + CIW'(1); cneg = 1'b0;
        end
        2'd1: begin
          cr = RIW'(load_row) + RIW'(1); cc = CIW'(load_col); cneg = 1'b0;
        end
        default: begin
          cr = RIW'(load_row); cc = CIW'(load_col); cneg = 1'b1;
        end
      endcase
    end
    czero     = (cr == '0) || (cc == '0);
    tab_raddr = {RAW'(cr - RIW'(1)), CAW'(cc - CIW'(1))};
    ncorners  = is_query ? 3'd4 : 3'd3;
    rd_issue  = rd_k < ncorners;
    rd_done   = rd_k == ncorners;
  end

  // datapath terms
  always_comb begin
    in_mag   = req.elevation[E-1] ? (E'(0) - E'(req.elevation)) : E'(req.elevation);
    in_sq    = in_mag * in_mag;
    cmag     = centre[E-1] ? (E'(0) - centre) : centre;
    smag     = acc_s[SUM_W-1] ? (SUM_W'(0) - acc_s) : acc_s;
    nmag     = num[NUM_W-1] ? (NUM_W'(0) - num) : num;
    prod_s   = centre[E-1] ? (NUM_W'(0) - mul_acc[NUM_W-1:0]) : mul_acc[NUM_W-1:0];
    cap_n    = rd_zero ? '0 : tn_rdata;
    cap_s    = rd_zero ? '0 : ts_rdata;
    cap_q    = rd_zero ? '0 : tq_rdata;
    outside  = ({1'b0, qr} >= out_rows) || ({1'b0, qc} >= out_cols) ||
               (pr >= PW'(rows_eff)) || (pc >= PW'(cols_eff));
    skip     = (rad > {1'b0, pad_width}) ||
               (pr + PW'(rad) + PW'(1) > PW'(rows_eff)) ||
               (pc + PW'(rad) + PW'(1) > PW'(cols_eff));
    d_zero   = a_prod <= mul_acc;
    div_t    = {rem, div_num[DVW-1]};
    div_ge   = div_t >= {1'b0, d_val};
    sq_trial = sq_r + sq_bit;
    sq_ge    = sq_x >= sq_trial;
    out_free = !rsp_valid || rsp_ready;
    dev_pos  = {1'b0, best_mag};
    ld_addr  = {load_row, load_col};
    cell_raddr = {pr[RAW-1:0], pc[CAW-1:0]};
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      msmd_pkg::ST_CLEAR: if (clr_addr == '1) state_next = msmd_pkg::ST_IDLE;
      msmd_pkg::ST_IDLE: begin
        if (req_valid) begin
          state_next = (req.func == msmd_pkg::FUNC_LOAD) ? msmd_pkg::ST_RD
                                                         : msmd_pkg::ST_QCHK;
        end
      end
      msmd_pkg::ST_RD: begin
        if (rd_done) state_next = is_query ? msmd_pkg::ST_REVAL : msmd_pkg::ST_LWR;
      end
      msmd_pkg::ST_LWR:  state_next = msmd_pkg::ST_IDLE;
      msmd_pkg::ST_QCHK: state_next = outside ? msmd_pkg::ST_OUT : msmd_pkg::ST_QCEN;
      msmd_pkg::ST_QCEN: state_next = cell_rdata[E] ? msmd_pkg::ST_RCHK : msmd_pkg::ST_OUT;
      msmd_pkg::ST_RCHK: begin
        if (rad > {1'b0, radius_max}) state_next = msmd_pkg::ST_OUT;
        else if (skip) state_next = msmd_pkg::ST_RNXT;
        else state_next = msmd_pkg::ST_RD;
      end
      msmd_pkg::ST_REVAL: state_next = (acc_n == '0) ? msmd_pkg::ST_RNXT : msmd_pkg::ST_MNC;
      msmd_pkg::ST_MNC: if (mul_b == '0) state_next = msmd_pkg::ST_MNQ;
      msmd_pkg::ST_MNQ: if (mul_b == '0) state_next = msmd_pkg::ST_MSS;
      msmd_pkg::ST_MSS: begin
        if (mul_b == '0) state_next = d_zero ? msmd_pkg::ST_UPD : msmd_pkg::ST_MNN;
      end
      msmd_pkg::ST_MNN: if (mul_b == '0) state_next = msmd_pkg::ST_DIV;
      msmd_pkg::ST_DIV: begin
        if (div_cnt == '0) state_next = quo_sat ? msmd_pkg::ST_UPD : msmd_pkg::ST_SQRT;
      end
      msmd_pkg::ST_SQRT: if (sq_bit == '0) state_next = msmd_pkg::ST_UPD;
      msmd_pkg::ST_UPD:  state_next = msmd_pkg::ST_RNXT;
      msmd_pkg::ST_RNXT: state_next = msmd_pkg::ST_RCHK;
      msmd_pkg::ST_OUT:  if (out_free) state_next = msmd_pkg::ST_IDLE;
      default:           state_next = msmd_pkg::ST_IDLE;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    req_ready = state == msmd_pkg::ST_IDLE;
    tab_we    = (state == msmd_pkg::ST_CLEAR) || (state == msmd_pkg::ST_LWR);
    tab_waddr = (state == msmd_pkg::ST_CLEAR) ? clr_addr : ld_addr;
    tn_wdata  = (state == msmd_pkg::ST_CLEAR) ? '0 : acc_n;
    ts_wdata  = (state == msmd_pkg::ST_CLEAR) ? '0 : acc_s;
    tq_wdata  = (state == msmd_pkg::ST_CLEAR) ? '0 : acc_q;
    cell_we   = state == msmd_pkg::ST_LWR;
  end

  // state register, configuration and load position
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= msmd_pkg::ST_CLEAR;
      clr_addr    <= '0;
      load_row    <= '0;
      load_col    <= '0;
      padded_rows <= 7'd64;
      padded_cols <= 7'd64;
      pad_width   <= 5'd0;
      out_rows    <= 7'd64;
      out_cols    <= 7'd64;
      radius_min  <= 5'd1;
      radius_max  <= 5'd1;
      radius_step <= 5'd1;
      rsp_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == msmd_pkg::ST_CLEAR) clr_addr <= clr_addr + AW'(1);
      // restart loading on a bad position, advance after each write
      if (state == msmd_pkg::ST_IDLE && req_valid && req.func == msmd_pkg::FUNC_LOAD) begin
        if (RIW'(load_row) >= rows_eff || CIW'(load_col) >= cols_eff) begin
          load_row <= '0;
          load_col <= '0;
        end
      end
      if (state == msmd_pkg::ST_LWR) begin
        if (RIW'(load_row) + RIW'(1) >= rows_eff) begin
          load_row <= '0;
          load_col <= (CIW'(load_col) + CIW'(1) >= cols_eff) ? '0 : load_col + CAW'(1);
        end else begin
          load_row <= load_row + RAW'(1);
        end
      end
      if (cfg_we) begin
        case (msmd_pkg::cfg_index_t'(cfg_index))
          msmd_pkg::CFG_PADDED_ROWS: begin
            padded_rows <= cfg_data;
            load_row    <= '0;
            load_col    <= '0;
          end
          msmd_pkg::CFG_PADDED_COLS: begin
            padded_cols <= cfg_data;
            load_row    <= '0;
            load_col    <= '0;
          end
          msmd_pkg::CFG_PAD_WIDTH:   pad_width   <= cfg_data[4:0];
          msmd_pkg::CFG_OUT_ROWS:    out_rows    <= cfg_data;
          msmd_pkg::CFG_OUT_COLS:    out_cols    <= cfg_data;
          msmd_pkg::CFG_RADIUS_MIN:  radius_min  <= cfg_data[4:0];
          msmd_pkg::CFG_RADIUS_MAX:  radius_max  <= cfg_data[4:0];
          msmd_pkg::CFG_RADIUS_STEP: radius_step <= cfg_data[4:0];
          default: ;
        endcase
      end
      // hand off the result word
      if (state == msmd_pkg::ST_OUT && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      msmd_pkg::ST_IDLE: begin
        rd_k     <= '0;
        have     <= 1'b0;
        is_query <= req.func;
        ld_ok    <= req.elevation_valid;
        ld_e     <= E'(req.elevation);
        qr       <= req.query_row;
        qc       <= req.query_col;
        pr       <= PW'(req.query_row) + PW'(pad_width);
        pc       <= PW'(req.query_col) + PW'(pad_width);
        acc_n    <= CNT_W'(req.elevation_valid);
        acc_s    <= req.elevation_valid ? SUM_W'(req.elevation) : '0;
        acc_q    <= req.elevation_valid ? SQ_W'(in_sq) : '0;
      end
      msmd_pkg::ST_RD: begin
        // issue one corner read, fold in the previous one
        rd_k    <= rd_k + 3'd1;
        if (rd_issue) begin
          rd_zero <= czero;
          rd_neg  <= cneg;
        end
        if (rd_k != 3'd0) begin
          acc_n <= rd_neg ? acc_n - cap_n : acc_n + cap_n;
          acc_s <= rd_neg ? acc_s - cap_s : acc_s + cap_s;
          acc_q <= rd_neg ? acc_q - cap_q : acc_q + cap_q;
        end
      end
      msmd_pkg::ST_QCEN: begin
        centre <= cell_rdata[E-1:0];
        rad    <= {1'b0, radius_min};
      end
      msmd_pkg::ST_RCHK: begin
        r0    <= RIW'(pr - PW'(rad));
        r1    <= RIW'(pr + PW'(rad) + PW'(1));
        c0    <= CIW'(pc - PW'(rad));
        c1    <= CIW'(pc + PW'(rad) + PW'(1));
        rd_k  <= '0;
        acc_n <= '0;
        acc_s <= '0;
        acc_q <= '0;
      end
      msmd_pkg::ST_REVAL: begin
        mul_a   <= MW'(cmag);
        mul_b   <= NUM_W'(acc_n);
        mul_acc <= '0;
      end
      msmd_pkg::ST_MNC, msmd_pkg::ST_MNQ, msmd_pkg::ST_MSS, msmd_pkg::ST_MNN: begin
        if (mul_b != '0) begin
          // one shift-add step of the shared multiplier
          if (mul_b[0]) mul_acc <= mul_acc + mul_a;
          mul_a <= mul_a << 1;
          mul_b <= mul_b >> 1;
        end else begin
          mul_acc <= '0;
          case (state)
            msmd_pkg::ST_MNC: begin
              num   <= prod_s - {acc_s[SUM_W-1], acc_s};
              mul_a <= MW'(acc_q);
              mul_b <= NUM_W'(acc_n);
            end
            msmd_pkg::ST_MNQ: begin
              a_prod <= mul_acc;
              mul_a  <= MW'(smag);
              mul_b  <= NUM_W'(smag);
            end
            msmd_pkg::ST_MSS: begin
              d_val <= a_prod - mul_acc;
              m_val <= '0;
              mul_a <= MW'(nmag);
              mul_b <= nmag;
            end
            default: begin
              div_num <= {mul_acc, 32'd0};
              rem     <= '0;
              quo     <= '0;
              quo_sat <= 1'b0;
              div_cnt <= DCW'(DVW);
            end
          endcase
        end
      end
      msmd_pkg::ST_DIV: begin
        if (div_cnt != '0) begin
          // one restoring divide step
          rem     <= div_ge ? MW'(div_t - {1'b0, d_val}) : MW'(div_t);
          div_num <= div_num << 1;
          quo     <= {quo[QW-2:0], div_ge};
          quo_sat <= quo_sat | quo[QW-1];
          div_cnt <= div_cnt - DCW'(1);
        end else begin
          m_val  <= MAX_MAG;
          sq_x   <= quo;
          sq_r   <= '0;
          sq_bit <= QW'(1) << (QW - 2);
        end
      end
      msmd_pkg::ST_SQRT: begin
        if (sq_bit != '0) begin
          // one bit pair of the square root
          if (sq_ge) begin
            sq_x <= sq_x - sq_trial;
            sq_r <= (sq_r >> 1) + sq_bit;
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_bit <= sq_bit >> 2;
        end else begin
          m_val <= sq_r[MAGW-1:0];
        end
      end
      msmd_pkg::ST_UPD: begin
        // keep the first score of largest magnitude
        if (!have || m_val > best_mag) begin
          best_mag <= m_val;
          best_neg <= num[NUM_W-1];
          have     <= 1'b1;
        end
      end
      msmd_pkg::ST_RNXT: rad <= rad + step_eff;
      msmd_pkg::ST_OUT: begin
        if (out_free) begin
          rsp.deviation_valid <= have;
          rsp.deviation       <= !have ? '0 :
                                 (best_neg ? DEV_W_L'(0) - dev_pos : dev_pos);
        end
      end
      default: ;
    endcase
  end

  msmd_ram #(.W(CNT_W), .AW(AW)) u_count_table (
    .clk(clk), .we(tab_we), .waddr(tab_waddr), .wdata(tn_wdata),
    .raddr(tab_raddr), .rdata(tn_rdata)
  );

  msmd_ram #(.W(SUM_W), .AW(AW)) u_sum_table (
    .clk(clk), .we(tab_we), .waddr(tab_waddr), .wdata(ts_wdata),
    .raddr(tab_raddr), .rdata(ts_rdata)
  );

  msmd_ram #(.W(SQ_W), .AW(AW)) u_square_sum_table (
    .clk(clk), .we(tab_we), .waddr(tab_waddr), .wdata(tq_wdata),
    .raddr(tab_raddr), .rdata(tq_rdata)
  );

  msmd_ram #(.W(E + 1), .AW(AW)) u_cell_store (
    .clk(clk), .we(cell_we), .waddr(ld_addr), .wdata({ld_ok, ld_e}),
    .raddr(cell_raddr), .rdata(cell_rdata)
  );

endmodule
`default_nettype wire

>>> verif/multiscale_max_deviation_unit_tb.sv
// Self-checking testbench for the multiscale max deviation unit with a scoreboard class.
`default_nettype none

module multiscale_max_deviation_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REQ_W = $bits(msmd_pkg::req_t);

  // Predicts deviation results from loaded cells and holds the results still owed
  class deviation_scoreboard;
    int unsigned count_tab [0:64][0:64];
    bit [63:0]   sum_tab   [0:64][0:64];
    bit [63:0]   sq_tab    [0:64][0:64];
    bit [24:0]   cells     [0:63][0:63];
    bit          written   [0:63][0:63];
    int unsigned ld_row, ld_col;
    int unsigned rows_reg, cols_reg, pad_reg, orows_reg, ocols_reg;
    int unsigned rmin_reg, rmax_reg, rstep_reg;
    msmd_pkg::rsp_t owed [$];
    int          errors, loads, queries, valid_scores;

    function new();
      for (int r = 0; r <= 64; r++)
        for (int c = 0; c <= 64; c++) begin
          count_tab[r][c] = 0;
          sum_tab[r][c] = 0;
          sq_tab[r][c] = 0;
        end
      for (int r = 0; r < 64; r++)
        for (int c = 0; c < 64; c++) begin
          cells[r][c] = 0;
          written[r][c] = 0;
        end
      ld_row = 0; ld_col = 0;
      rows_reg = 64; cols_reg = 64; pad_reg = 0; orows_reg = 64; ocols_reg = 64;
      rmin_reg = 1; rmax_reg = 1; rstep_reg = 1;
      errors = 0; loads = 0; queries = 0; valid_scores = 0;
    endfunction

    function int unsigned rows_eff();
      return rows_reg == 0 ? 1 : (rows_reg > 64 ? 64 : rows_reg);
    endfunction

    function int unsigned cols_eff();
      return cols_reg == 0 ? 1 : (cols_reg > 64 ? 64 : cols_reg);
    endfunction

    function void write_reg(msmd_pkg::cfg_index_t idx, int unsigned v);
      case (idx)
        msmd_pkg::CFG_PADDED_ROWS: begin
          rows_reg = v & 32'h7f; ld_row = 0; ld_col = 0;
        end
        msmd_pkg::CFG_PADDED_COLS: begin
          cols_reg = v & 32'h7f; ld_row = 0; ld_col = 0;
        end
        msmd_pkg::CFG_PAD_WIDTH:   pad_reg = v & 32'h1f;
        msmd_pkg::CFG_OUT_ROWS:    orows_reg = v & 32'h7f;
        msmd_pkg::CFG_OUT_COLS:    ocols_reg = v & 32'h7f;
        msmd_pkg::CFG_RADIUS_MIN:  rmin_reg = v & 32'h1f;
        msmd_pkg::CFG_RADIUS_MAX:  rmax_reg = v & 32'h1f;
        msmd_pkg::CFG_RADIUS_STEP: rstep_reg = v & 32'h1f;
        default: ;
      endcase
    endfunction

    // True when a query word would read a cell never loaded since reset
    function bit reads_unwritten(msmd_pkg::req_t w);
      int unsigned pr, pc;
      pr = 32'(w.query_row) + pad_reg;
      pc = 32'(w.query_col) + pad_reg;
      if (w.func != msmd_pkg::FUNC_QUERY) return 0;
      if (w.query_row >= orows_reg || w.query_col >= ocols_reg) return 0;
      if (pr >= rows_eff() || pc >= cols_eff()) return 0;
      return !written[pr][pc];
    endfunction

    function bit [63:0] isqrt(bit [63:0] x);
      bit [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (x >= res + bitv) begin
          x = x - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function void load_cell(msmd_pkg::req_t w);
      longint    v;
      bit [63:0] vu, mag, sq;
      int unsigned r, c;
      v = w.elevation_valid ? longint'(w.elevation) : 64'sd0;
      if (ld_row >= rows_eff() || ld_col >= cols_eff()) begin
        ld_row = 0; ld_col = 0;
      end
      r = ld_row; c = ld_col;
      vu = v;
      mag = v < 0 ? -vu : vu;
      sq = mag * mag;
      cells[r][c] = {w.elevation_valid, w.elevation};
      written[r][c] = 1;
      count_tab[r+1][c+1] = 32'(w.elevation_valid) + count_tab[r][c+1] + count_tab[r+1][c]
                            - count_tab[r][c];
      sum_tab[r+1][c+1] = vu + sum_tab[r][c+1] + sum_tab[r+1][c] - sum_tab[r][c];
      sq_tab[r+1][c+1] = sq + sq_tab[r][c+1] + sq_tab[r+1][c] - sq_tab[r][c];
      // advance down the column, then to the next column
      ld_row++;
      if (ld_row >= rows_eff()) begin
        ld_row = 0;
        ld_col++;
        if (ld_col >= cols_eff()) ld_col = 0;
      end
    endfunction

    function msmd_pkg::rsp_t score_query(int unsigned qr, int unsigned qc);
      msmd_pkg::rsp_t res;
      int unsigned pr, pc, stp, r0, r1, c0, c1, n;
      longint      centre;
      bit [63:0]   centre_u, s, q, num, smag, nmag, m, best_mag;
      bit [127:0]  wa, wd, wn, wq, wt;
      bit          have, best_neg;
      res = '0;
      have = 0; best_neg = 0; best_mag = 0;
      pr = qr + pad_reg;
      pc = qc + pad_reg;
      if (qr >= orows_reg || qc >= ocols_reg || pr >= rows_eff() || pc >= cols_eff())
        return res;
      if (!cells[pr][pc][24]) return res;
      centre = longint'($signed(cells[pr][pc][23:0]));
      centre_u = centre;
      stp = rstep_reg == 0 ? 1 : rstep_reg;
      for (int unsigned rad = rmin_reg; rad <= rmax_reg; rad += stp) begin
        if (rad > pad_reg || pr + rad + 1 > rows_eff() || pc + rad + 1 > cols_eff()) continue;
        r0 = pr - rad; r1 = pr + rad + 1; c0 = pc - rad; c1 = pc + rad + 1;
        n = count_tab[r1][c1] - count_tab[r0][c1] - count_tab[r1][c0] + count_tab[r0][c0];
        if (n == 0) continue;
        s = sum_tab[r1][c1] - sum_tab[r0][c1] - sum_tab[r1][c0] + sum_tab[r0][c0];
        q = sq_tab[r1][c1] - sq_tab[r0][c1] - sq_tab[r1][c0] + sq_tab[r0][c0];
        num = 64'(n) * centre_u - s;
        smag = s[63] ? -s : s;
        nmag = num[63] ? -num : num;
        wn = 128'(n); wq = 128'(q);
        wa = wn * wq;
        wt = 128'(smag);
        wd = wt * wt;
        wd = (wa < wd) ? 128'd0 : wa - wd;
        if (wd == 0) begin
          m = 0;
        end else begin
          wt = 128'(nmag);
          wt = wt * wt;
          wt = wt << 32;
          wt = wt / wd;
          m = (wt[127:64] != 0) ? 64'h7fffffff : isqrt(wt[63:0]);
          if (m > 64'h7fffffff) m = 64'h7fffffff;
        end
        // keep the first score on ties
        if (!have || m > best_mag) begin
          best_mag = m; best_neg = num[63]; have = 1;
        end
      end
      if (!have) return res;
      res.deviation_valid = 1;
      res.deviation = best_neg ? -best_mag[31:0] : best_mag[31:0];
      return res;
    endfunction

    function void note_word(msmd_pkg::req_t w);
      if (w.func == msmd_pkg::FUNC_LOAD) begin
        load_cell(w);
        loads++;
      end else begin
        owed.push_back(score_query(32'(w.query_row), 32'(w.query_col)));
        queries++;
      end
    endfunction

    function void check_word(msmd_pkg::rsp_t got);
      msmd_pkg::rsp_t want;
      if (owed.size() == 0) begin
        $error("unexpected result word: deviation %0d valid %0d",
               got.deviation, got.deviation_valid);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (want.deviation_valid) valid_scores++;
      if (got.deviation_valid !== want.deviation_valid) begin
        $error("deviation_valid: expected %0d actual %0d",
               want.deviation_valid, got.deviation_valid);
        errors++;
      end
      if (got.deviation !== want.deviation) begin
        $error("deviation: expected %0d actual %0d", want.deviation, got.deviation);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 req_valid;
  logic                 req_ready;
  msmd_pkg::req_t       req;
  logic                 rsp_valid;
  logic                 rsp_ready;
  msmd_pkg::rsp_t       rsp;
  logic                 cfg_we;
  logic [msmd_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [msmd_pkg::CFG_W-1:0]     cfg_data;

  deviation_scoreboard sb;
  int send_idle;
  int recv_stall;
  int words_sent;
  int phases_run;

  multiscale_max_deviation_unit uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Bound the run
  initial begin
    #80ms;
    $display("FAILURE");
    $finish;
  end

  // Hold off the sender at random, then present one word until it is taken
  task automatic send_word(msmd_pkg::req_t w);
    while (int'($urandom_range(99)) < send_idle) begin
      @(negedge clk);
      req_valid = 0;
    end
    @(negedge clk);
    req_valid = 1;
    req = w;
    do @(posedge clk); while (!req_ready);
    sb.note_word(w);
    words_sent++;
  endtask

  task automatic send_load(logic signed [23:0] elev, logic ok);
    msmd_pkg::req_t w;
    w = '0;
    w.func = msmd_pkg::FUNC_LOAD;
    w.elevation = elev;
    w.elevation_valid = ok;
    send_word(w);
  endtask

  task automatic send_query(int unsigned qr, int unsigned qc);
    msmd_pkg::req_t w;
    w = '0;
    w.func = msmd_pkg::FUNC_QUERY;
    w.query_row = 6'(qr);
    w.query_col = 6'(qc);
    w.elevation = 24'($urandom);
    w.elevation_valid = 1'($urandom_range(1));
    if (sb.reads_unwritten(w)) w.func = msmd_pkg::FUNC_LOAD;
    send_word(w);
  endtask

  // Drop valid and wait until every owed result has come back
  task automatic drain();
    @(negedge clk);
    req_valid = 0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_reg(msmd_pkg::cfg_index_t idx, int unsigned v);
    @(negedge clk);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = msmd_pkg::CFG_W'(v);
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic configure(int unsigned rows, int unsigned cols, int unsigned pad,
                           int unsigned orows, int unsigned ocols,
                           int unsigned rmin, int unsigned rmax, int unsigned rstep);
    set_reg(msmd_pkg::CFG_PADDED_ROWS, rows);
    set_reg(msmd_pkg::CFG_PADDED_COLS, cols);
    set_reg(msmd_pkg::CFG_PAD_WIDTH, pad);
    set_reg(msmd_pkg::CFG_OUT_ROWS, orows);
    set_reg(msmd_pkg::CFG_OUT_COLS, ocols);
    set_reg(msmd_pkg::CFG_RADIUS_MIN, rmin);
    set_reg(msmd_pkg::CFG_RADIUS_MAX, rmax);
    set_reg(msmd_pkg::CFG_RADIUS_STEP, rstep);
  endtask

  // One phase: random or fixed corner-case settings, a full raster load, queries, then a little noise
  task automatic random_phase(int ph);
    int unsigned rows, cols, pad, orows, ocols, rmin, rmax, rstep, nq, ro, co, style;
    int          base;
    msmd_pkg::req_t w;
    rows = $urandom_range(1, 10);
    cols = $urandom_range(1, 10);
    pad = $urandom_range(0, 3);
    rmin = $urandom_range(0, 3);
    rmax = $urandom_range(0, 4);
    rstep = $urandom_range(1, 3);
    orows = $urandom_range(1, rows);
    ocols = $urandom_range(1, cols);
    case (ph)
      1: begin
        rows = 0; cols = 127; pad = 0; orows = 0; ocols = 127;
        rmin = 0; rmax = 0; rstep = 0;
      end
      2: begin
        rows = 127; cols = 3; pad = 31; orows = 64; ocols = 64;
        rmin = 31; rmax = 31; rstep = 31;
      end
      3: begin
        rows = 64; cols = 3; pad = 1; orows = 127; ocols = 1;
        rmin = 0; rmax = 31; rstep = 1;
      end
      4: begin
        rmin = 3; rmax = 1;
      end
      default: begin
        if ($urandom_range(9) == 0) rstep = 0;
        if ($urandom_range(9) == 0) pad = $urandom_range(4, 31);
        if ($urandom_range(7) == 0) orows = $urandom_range(0, 127);
        if ($urandom_range(7) == 0) ocols = $urandom_range(0, 127);
      end
    endcase
    send_idle  = (ph % 4 == 1) ? 55 : (ph % 4 == 3) ? 21 : 0;
    recv_stall = (ph % 4 == 2) ? 55 : (ph % 4 == 3) ? 21 : 0;
    configure(rows, cols, pad, orows, ocols, rmin, rmax, rstep);
    style = $urandom_range(2);
    base = int'($urandom_range(0, 200000)) - 100000;
    // load the whole raster
    for (int i = 0; i < int'(sb.rows_eff() * sb.cols_eff()); i++) begin
      case (style)
        0: send_load(24'($urandom), $urandom_range(9) != 0);
        1: send_load(24'(base + int'($urandom_range(0, 200)) - 100),
                     $urandom_range(9) != 0);
        default: send_load(24'(base), 1'b1);
      endcase
    end
    ro = (sb.orows_reg == 0) ? 1 : (sb.orows_reg > 64 ? 64 : sb.orows_reg);
    co = (sb.ocols_reg == 0) ? 1 : (sb.ocols_reg > 64 ? 64 : sb.ocols_reg);
    nq = $urandom_range(8, 20);
    for (int i = 0; i < int'(nq); i++) begin
      if ($urandom_range(4) == 0) send_query($urandom_range(0, 63), $urandom_range(0, 63));
      else send_query($urandom_range(0, ro - 1), $urandom_range(0, co - 1));
    end
    // noise: random words of either kind
    for (int i = 0; i < 5; i++) begin
      w = REQ_W'({$urandom, $urandom});
      if (sb.reads_unwritten(w)) w.func = msmd_pkg::FUNC_LOAD;
      send_word(w);
    end
    drain();
  endtask

  // Sample results at the rising edge, change ready at the falling edge
  initial begin
    rsp_ready = 0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && rsp_ready) sb.check_word(rsp);
      @(negedge clk);
      rsp_ready = int'($urandom_range(99)) >= recv_stall;
    end
  end

  initial begin
    int ph;
    sb = new();
    rst = 1;
    req_valid = 0;
    req = '0;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle = 0;
    recv_stall = 0;
    words_sent = 0;
    phases_run = 0;
    repeat (5) @(negedge clk);
    rst = 0;

    // Directed: 4x4 raster with extreme and invalid cells, radii 0 and 1
    configure(4, 4, 1, 2, 2, 0, 1, 1);
    for (int i = 0; i < 16; i++) begin
      if (i == 5) send_load(24'sh7fffff, 1'b1);
      else if (i == 6) send_load(-24'sh800000, 1'b1);
      else if (i == 9) send_load(24'sh000123, 1'b0);
      else send_load(24'(i * 3), 1'b1);
    end
    send_query(0, 0);
    send_query(1, 0);
    send_query(0, 1);
    send_query(1, 1);
    send_query(2, 0);
    send_query(0, 63);
    drain();
    phases_run = 1;

    ph = 1;
    while (words_sent < 750) begin
      random_phase(ph);
      ph++;
      phases_run++;
    end
    drain();

    $display("Covered %0d phases: %0d loads and %0d queries, %0d of them scored valid.",
             phases_run, sb.loads, sb.queries, sb.valid_scores);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
